// ===== design/gfv_pkg.sv =====
package gfv_pkg;

   // default sample width of the neighbourhood samples
   localparam int SAMPLE_BITS_DEFAULT = 8;

   // strength register, unsigned Q8.8
   localparam int                       STRENGTH_BITS  = 16;
   localparam logic [STRENGTH_BITS-1:0] STRENGTH_RESET = 16'd256;

   // force components, signed Q8.8
   localparam int FORCE_BITS = 17;

   // words held between the classifying front and the arithmetic back
   localparam int QUEUE_DEPTH = 4;

endpackage

// ===== design/gfv_channels.sv =====
// neighbourhood channel: eight neighbours and the centre sample
interface gfv_req_if #(
   parameter int SAMPLE_BITS = gfv_pkg::SAMPLE_BITS_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] north_west_value;
   logic [SAMPLE_BITS-1:0] north_value;
   logic [SAMPLE_BITS-1:0] north_east_value;
   logic [SAMPLE_BITS-1:0] east_value;
   logic [SAMPLE_BITS-1:0] south_east_value;
   logic [SAMPLE_BITS-1:0] south_value;
   logic [SAMPLE_BITS-1:0] south_west_value;
   logic [SAMPLE_BITS-1:0] west_value;
   logic [SAMPLE_BITS-1:0] center_value;

   modport source (
      output valid, north_west_value, north_value, north_east_value, east_value,
             south_east_value, south_value, south_west_value, west_value, center_value,
      input  ready
   );
   modport sink (
      input  valid, north_west_value, north_value, north_east_value, east_value,
             south_east_value, south_value, south_west_value, west_value, center_value,
      output ready
   );
endinterface

// force channel: signed Q8.8 components
interface gfv_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [gfv_pkg::FORCE_BITS-1:0]  force_x;
   logic signed [gfv_pkg::FORCE_BITS-1:0]  force_y;

   modport source (output valid, force_x, force_y, input ready);
   modport sink   (input valid, force_x, force_y, output ready);
endinterface

// ===== design/gfv_front.sv =====
// Front: takes a neighbourhood, forms the Prewitt differences and classifies
// the zero gradient, then offers the word to the queue.
module gfv_front #(
   parameter int SAMPLE_BITS = gfv_pkg::SAMPLE_BITS_DEFAULT,
   parameter int ENTRY_BITS  = 3 + 2 * (SAMPLE_BITS + 2) + SAMPLE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   gfv_req_if.sink               req_bus,
   output logic                  q_valid,
   input  logic                  q_ready,
   output logic [ENTRY_BITS-1:0] q_data
);

   localparam int DB = SAMPLE_BITS + 2;   // magnitude of a difference

   typedef struct packed {
      logic                   zero;
      logic                   neg_x;
      logic [DB-1:0]          abs_x;
      logic                   neg_y;
      logic [DB-1:0]          abs_y;
      logic [SAMPLE_BITS-1:0] center;
   } entry_type;

   logic          f_valid_ff, f_valid_in;
   entry_type     f_entry_ff, f_entry_in;
   entry_type     entry_new;
   logic [DB-1:0] left_sum, right_sum, top_sum, bottom_sum;
   logic [DB:0]   dx, dy;
   logic          load;

   // column and row sums
   always_comb begin
      left_sum   = DB'(req_bus.north_west_value) + DB'(req_bus.west_value)
                 + DB'(req_bus.south_west_value);
      right_sum  = DB'(req_bus.north_east_value) + DB'(req_bus.east_value)
                 + DB'(req_bus.south_east_value);
      top_sum    = DB'(req_bus.north_west_value) + DB'(req_bus.north_value)
                 + DB'(req_bus.north_east_value);
      bottom_sum = DB'(req_bus.south_west_value) + DB'(req_bus.south_value)
                 + DB'(req_bus.south_east_value);
      dx = {1'b0, left_sum} - {1'b0, right_sum};
      dy = {1'b0, top_sum} - {1'b0, bottom_sum};
   end

   // sign and magnitude, zero gradient flag
   always_comb begin
      entry_new.zero   = (dx == '0) && (dy == '0);
      entry_new.neg_x  = dx[DB];
      entry_new.abs_x  = dx[DB] ? DB'(-dx) : dx[DB-1:0];
      entry_new.neg_y  = dy[DB];
      entry_new.abs_y  = dy[DB] ? DB'(-dy) : dy[DB-1:0];
      entry_new.center = req_bus.center_value;
   end

   assign req_bus.ready = !f_valid_ff || q_ready;
   assign load          = req_bus.valid && req_bus.ready;

   always_comb begin
      f_valid_in = f_valid_ff;
      f_entry_in = f_entry_ff;
      if (load) begin
         f_valid_in = 1'b1;
         f_entry_in = entry_new;
      end else if (q_ready) begin
         f_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
      f_entry_ff <= f_entry_in;
   end

   assign q_valid = f_valid_ff;
   assign q_data  = ENTRY_BITS'(f_entry_ff);

   // a word refused by the queue stays put
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      f_valid_ff && !q_ready |=> f_valid_ff && $stable(f_entry_ff))
      else $error("front word changed while queue was full");

endmodule

// ===== design/gfv_queue.sv =====
// Short first-word-fall-through queue between front and back.
module gfv_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = gfv_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CB = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PB-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CB-1:0]    count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CB'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PB'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PB'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   a_queue_fill: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill count lost a word");

endmodule

// ===== design/gfv_root_step.sv =====
// One digit of the scaled square root: finds bit BIT of the largest r with
// r*r*den <= rem. Keeps prod = r*den so that each step is shift and add only.
module gfv_root_step #(
   parameter int CW  = 72,
   parameter int DW  = 37,
   parameter int RB  = 17,
   parameter int BIT = 0
) (
   input  logic             clock,
   input  logic             en,
   input  logic [CW-1:0]    src_rem,
   input  logic [DW+RB-1:0] src_prod,
   input  logic [RB-1:0]    src_root,
   input  logic [DW-1:0]    src_den,
   output logic [CW-1:0]    dst_rem,
   output logic [DW+RB-1:0] dst_prod,
   output logic [RB-1:0]    dst_root,
   output logic [DW-1:0]    dst_den
);

   localparam int PW = DW + RB;

   logic [CW-1:0] trial;
   logic          take;
   logic [CW-1:0] rem_ff, rem_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [RB-1:0] root_ff, root_in;
   logic [DW-1:0] den_ff;

   // (r + 2^b)^2 * den - r^2 * den = prod * 2^(b+1) + den * 2^(2b)
   always_comb begin
      trial   = (CW'(src_prod) << (BIT + 1)) + (CW'(src_den) << (2 * BIT));
      take    = (trial <= src_rem);
      rem_in  = take ? src_rem - trial : src_rem;
      prod_in = take ? src_prod + (PW'(src_den) << BIT) : src_prod;
      root_in = take ? src_root | (RB'(1) << BIT) : src_root;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         prod_ff <= prod_in;
         root_ff <= root_in;
         den_ff  <= src_den;
      end
   end

   assign dst_rem  = rem_ff;
   assign dst_prod = prod_ff;
   assign dst_root = root_ff;
   assign dst_den  = den_ff;

endmodule

// ===== design/gfv_back.sv =====
// Back: scales, squares and takes the rounded ratio
//    q = round(|d| * c * m / (SMAX * sqrt(dx^2 + dy^2)))
// as the largest q with ((2q-1) * SMAX)^2 * s <= (2 * |d| * c * m)^2,
// i.e. q = (r + 1) / 2 with r the integer root of N / D.
module gfv_back #(
   parameter int SAMPLE_BITS = gfv_pkg::SAMPLE_BITS_DEFAULT,
   parameter int ENTRY_BITS  = 3 + 2 * (SAMPLE_BITS + 2) + SAMPLE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [gfv_pkg::STRENGTH_BITS-1:0] max_strength,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [ENTRY_BITS-1:0]             in_data,
   gfv_rsp_if.source                         rsp_bus
);

   localparam int W   = SAMPLE_BITS;
   localparam int SB  = gfv_pkg::STRENGTH_BITS;
   localparam int FB  = gfv_pkg::FORCE_BITS;
   localparam int DB  = W + 2;                  // |dx|, |dy|
   localparam int AB  = DB + W + SB;            // |d| * c * m
   localparam int HL  = (AB + 1) / 2;           // low half for squaring
   localparam int HH  = AB - HL;
   localparam int NW  = 2 * AB + 2;             // (2 * |d| * c * m)^2
   localparam int DW  = 2 * DB + 1 + 2 * W;     // SMAX^2 * s
   localparam int RB  = SB + 1;                 // root bits, r <= 2m
   localparam int CW  = ((NW > DW + 2 * RB) ? NW : DW + 2 * RB) + 1;
   localparam int PW  = DW + RB;
   localparam int L   = 4 + RB;                 // stages before the output register
   localparam logic [2*W-1:0] SMAX_SQ =
      (2 * W)'(((64'd1 << W) - 64'd1) * ((64'd1 << W) - 64'd1));

   typedef struct packed {
      logic          zero;
      logic          neg_x;
      logic [DB-1:0] abs_x;
      logic          neg_y;
      logic [DB-1:0] abs_y;
      logic [W-1:0]  center;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic zero;
      logic neg_x;
      logic neg_y;
   } side_type;

   entry_type       entry;
   logic            en;
   side_type        sb_ff [L];
   side_type        sb_in [L];

   logic [DB+W-1:0] dc_x_ff, dc_y_ff;
   logic [2*DB-1:0] sq_x_ff, sq_y_ff;
   logic [AB-1:0]   a_x_ff, a_y_ff;
   logic [2*DB:0]   s_ff;
   logic [2*HL-1:0] ll_x_ff, ll_y_ff;
   logic [AB-1:0]   lh_x_ff, lh_y_ff;
   logic [2*HH-1:0] hh_x_ff, hh_y_ff;
   logic [DW-1:0]   d3_ff, d4_ff;
   logic [NW-1:0]   n_x_ff, n_y_ff;

   logic [CW-1:0]   rem_x  [RB+1];
   logic [PW-1:0]   prod_x [RB+1];
   logic [RB-1:0]   root_x [RB+1];
   logic [DW-1:0]   den_x  [RB+1];
   logic [CW-1:0]   rem_y  [RB+1];
   logic [PW-1:0]   prod_y [RB+1];
   logic [RB-1:0]   root_y [RB+1];
   logic [DW-1:0]   den_y  [RB+1];

   logic [SB-1:0]   q_x, q_y;
   logic            out_valid_ff, out_valid_in;
   logic [FB-1:0]   fx_ff, fx_in, fy_ff, fy_in;

   assign entry    = entry_type'(in_data);
   assign en       = !out_valid_ff || rsp_bus.ready;
   assign in_ready = en;

   // sideband travels beside the arithmetic
   always_comb begin
      sb_in[0].valid = in_valid;
      sb_in[0].zero  = entry.zero;
      sb_in[0].neg_x = entry.neg_x;
      sb_in[0].neg_y = entry.neg_y;
      for (int i = 1; i < L; i++) begin
         sb_in[i] = sb_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < L; i++) begin
            sb_ff[i] <= '0;
         end
      end else if (en) begin
         for (int i = 0; i < L; i++) begin
            sb_ff[i] <= sb_in[i];
         end
      end
   end

   // stages 1 to 4: products, sum of squares, split squaring of the numerator
   always_ff @(posedge clock) begin
      if (en) begin
         dc_x_ff <= (DB + W)'(entry.abs_x) * (DB + W)'(entry.center);
         dc_y_ff <= (DB + W)'(entry.abs_y) * (DB + W)'(entry.center);
         sq_x_ff <= (2 * DB)'(entry.abs_x) * (2 * DB)'(entry.abs_x);
         sq_y_ff <= (2 * DB)'(entry.abs_y) * (2 * DB)'(entry.abs_y);

         a_x_ff  <= AB'(dc_x_ff) * AB'(max_strength);
         a_y_ff  <= AB'(dc_y_ff) * AB'(max_strength);
         s_ff    <= (2 * DB + 1)'(sq_x_ff) + (2 * DB + 1)'(sq_y_ff);

         ll_x_ff <= (2 * HL)'(a_x_ff[HL-1:0]) * (2 * HL)'(a_x_ff[HL-1:0]);
         lh_x_ff <= AB'(a_x_ff[HL-1:0]) * AB'(a_x_ff[AB-1:HL]);
         hh_x_ff <= (2 * HH)'(a_x_ff[AB-1:HL]) * (2 * HH)'(a_x_ff[AB-1:HL]);
         ll_y_ff <= (2 * HL)'(a_y_ff[HL-1:0]) * (2 * HL)'(a_y_ff[HL-1:0]);
         lh_y_ff <= AB'(a_y_ff[HL-1:0]) * AB'(a_y_ff[AB-1:HL]);
         hh_y_ff <= (2 * HH)'(a_y_ff[AB-1:HL]) * (2 * HH)'(a_y_ff[AB-1:HL]);
         d3_ff   <= DW'(s_ff) * DW'(SMAX_SQ);

         n_x_ff  <= (NW'(hh_x_ff) << (2 * HL + 2)) + (NW'(lh_x_ff) << (HL + 3))
                  + (NW'(ll_x_ff) << 2);
         n_y_ff  <= (NW'(hh_y_ff) << (2 * HL + 2)) + (NW'(lh_y_ff) << (HL + 3))
                  + (NW'(ll_y_ff) << 2);
         d4_ff   <= d3_ff;
      end
   end

   // root digit chain, most significant bit first
   assign rem_x[0]  = CW'(n_x_ff);
   assign prod_x[0] = '0;
   assign root_x[0] = '0;
   assign den_x[0]  = d4_ff;
   assign rem_y[0]  = CW'(n_y_ff);
   assign prod_y[0] = '0;
   assign root_y[0] = '0;
   assign den_y[0]  = d4_ff;

   for (genvar k = 0; k < RB; k++) begin : g_root
      gfv_root_step #(.CW(CW), .DW(DW), .RB(RB), .BIT(RB - 1 - k)) u_step_x (
         .clock    (clock),
         .en       (en),
         .src_rem  (rem_x[k]),
         .src_prod (prod_x[k]),
         .src_root (root_x[k]),
         .src_den  (den_x[k]),
         .dst_rem  (rem_x[k+1]),
         .dst_prod (prod_x[k+1]),
         .dst_root (root_x[k+1]),
         .dst_den  (den_x[k+1])
      );
      gfv_root_step #(.CW(CW), .DW(DW), .RB(RB), .BIT(RB - 1 - k)) u_step_y (
         .clock    (clock),
         .en       (en),
         .src_rem  (rem_y[k]),
         .src_prod (prod_y[k]),
         .src_root (root_y[k]),
         .src_den  (den_y[k]),
         .dst_rem  (rem_y[k+1]),
         .dst_prod (prod_y[k+1]),
         .dst_root (root_y[k+1]),
         .dst_den  (den_y[k+1])
      );
   end

   // round, apply sign, zero gradient gives zero
   always_comb begin
      q_x = SB'(((RB + 1)'(root_x[RB]) + 1'b1) >> 1);
      q_y = SB'(((RB + 1)'(root_y[RB]) + 1'b1) >> 1);
      out_valid_in = out_valid_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      if (en) begin
         out_valid_in = sb_ff[L-1].valid;
         if (sb_ff[L-1].zero) begin
            fx_in = '0;
            fy_in = '0;
         end else begin
            fx_in = sb_ff[L-1].neg_x ? -FB'(q_x) : FB'(q_x);
            fy_in = sb_ff[L-1].neg_y ? -FB'(q_y) : FB'(q_y);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      fx_ff <= fx_in;
      fy_ff <= fy_in;
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.force_x = fx_ff;
   assign rsp_bus.force_y = fy_ff;

   a_back_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |->
         rsp_bus.force_x <= $signed({1'b0, max_strength})
         && rsp_bus.force_x >= -$signed({1'b0, max_strength})
         && rsp_bus.force_y <= $signed({1'b0, max_strength})
         && rsp_bus.force_y >= -$signed({1'b0, max_strength}))
      else $error("force component above configured strength");

   a_back_zero: assert property (@(posedge clock) disable iff (reset)
      en && sb_ff[L-1].valid && sb_ff[L-1].zero |=>
         rsp_bus.valid && rsp_bus.force_x == '0 && rsp_bus.force_y == '0)
      else $error("zero gradient gave a non-zero force");

endmodule

// ===== design/gradient_force_vector.sv =====
// Gradient force vector. Each word on req_bus is one 3x3 neighbourhood; the
// block forms the Prewitt differences (left minus right column, top minus
// bottom row), normalises them to unit length and scales by
// center_value / (2^SAMPLE_BITS - 1) * max_strength, giving signed Q8.8
// force components rounded to nearest with ties away from zero; a zero
// gradient gives a zero force. One word is taken every clock cycle when
// nothing stalls; each word passes the front register that holds it, the
// queue, four multiply stages, one root stage per result bit (17 for the
// 16-bit strength register) and the output register; the front and back
// are joined by a four-word queue so either side may stall alone. The back
// pipeline advances as a whole whenever its output register is free or
// being taken. max_strength resets to 1.0; the user is to write it through
// csr_write_enable and csr_write_data only while no word is in flight, as
// the block itself does not enforce this.
module gradient_force_vector #(
   parameter int SAMPLE_BITS = gfv_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   gfv_req_if.sink                           req_bus,
   gfv_rsp_if.source                         rsp_bus,
   input  logic                              csr_write_enable,
   input  logic [gfv_pkg::STRENGTH_BITS-1:0] csr_write_data
);

   localparam int ENTRY_BITS = 3 + 2 * (SAMPLE_BITS + 2) + SAMPLE_BITS;

   logic [gfv_pkg::STRENGTH_BITS-1:0] strength_ff, strength_in;
   logic                              fq_valid, fq_ready;
   logic [ENTRY_BITS-1:0]             fq_data;
   logic                              qb_valid, qb_ready;
   logic [ENTRY_BITS-1:0]             qb_data;

   // strength register
   assign strength_in = csr_write_enable ? csr_write_data : strength_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= gfv_pkg::STRENGTH_RESET;
      end else begin
         strength_ff <= strength_in;
      end
   end

   gfv_front #(.SAMPLE_BITS(SAMPLE_BITS), .ENTRY_BITS(ENTRY_BITS)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (fq_valid),
      .q_ready (fq_ready),
      .q_data  (fq_data)
   );

   gfv_queue #(.WIDTH(ENTRY_BITS), .DEPTH(gfv_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   gfv_back #(.SAMPLE_BITS(SAMPLE_BITS), .ENTRY_BITS(ENTRY_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .max_strength (strength_ff),
      .in_valid     (qb_valid),
      .in_ready     (qb_ready),
      .in_data      (qb_data),
      .rsp_bus      (rsp_bus)
   );

endmodule

// ===== tb/gradient_force_vector_tb.sv =====
`timescale 1ns / 100ps

module gradient_force_vector_tb;

   localparam int SBITS      = 8;
   localparam int SMAX       = (1 << SBITS) - 1;
   localparam int FBITS      = gfv_pkg::FORCE_BITS;
   localparam int STBITS     = gfv_pkg::STRENGTH_BITS;
   localparam int SETTLE     = 40;     // longer than the pipeline latency
   localparam int STALL_LIMIT = 3000;
   localparam int RAND_PER_PHASE = 205;
   localparam int NUM_PHASES = 8;

   typedef logic [SBITS-1:0] sample_type;
   typedef struct packed {
      sample_type nw, n, ne, e, se, s, sw, w, c;
   } hood_type;
   typedef struct packed {
      logic signed [FBITS-1:0] fx;
      logic signed [FBITS-1:0] fy;
   } force_type;
   typedef struct packed {
      logic      known;
      force_type value;
   } typed_type;
   typedef struct {
      hood_type  hood;
      logic      known;
      force_type value;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic [STBITS-1:0] csr_write_data   = '0;

   gfv_req_if #(.SAMPLE_BITS(SBITS)) req_bus ();
   gfv_rsp_if                        rsp_bus ();

   gradient_force_vector #(.SAMPLE_BITS(SBITS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus.sink),
      .rsp_bus          (rsp_bus.source),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   logic [STBITS-1:0] strength_copy = gfv_pkg::STRENGTH_RESET;
   force_type force_expected_q[$];
   typed_type typed_force_q[$];
   int        error_count = 0;
   int        quiet_cycles = 0;
   logic      calm = 1'b0;   // no idling on either side while set

   // rounded magnitude of one component, exact integer search
   function automatic logic signed [FBITS-1:0] force_part(
      int d, longint unsigned s, longint unsigned c, longint unsigned m);
      longint unsigned da, two_a, lo, hi, mid, x;
      logic [127:0] target, trial;
      da = (d < 0) ? longint'(-d) : longint'(d);
      two_a = 2 * da * c * m;
      target = 128'(two_a) * 128'(two_a);
      lo = 0;
      hi = m;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         x = (2 * mid - 1) * SMAX;
         trial = 128'(x) * 128'(x) * 128'(s);
         if (trial <= target) lo = mid;
         else hi = mid - 1;
      end
      return (d < 0) ? -FBITS'(lo) : FBITS'(lo);
   endfunction

   function automatic force_type predict_force(hood_type h, logic [STBITS-1:0] m);
      int dx, dy;
      longint unsigned s;
      force_type f;
      dx = (int'(h.nw) + int'(h.w) + int'(h.sw)) - (int'(h.ne) + int'(h.e) + int'(h.se));
      dy = (int'(h.nw) + int'(h.n) + int'(h.ne)) - (int'(h.sw) + int'(h.s) + int'(h.se));
      s = longint'(dx * dx) + longint'(dy * dy);
      f = '0;
      if (s != 0) begin
         f.fx = force_part(dx, s, h.c, m);
         f.fy = force_part(dy, s, h.c, m);
      end
      return f;
   endfunction

   // accepted neighbourhood: queue its expected force
   always @(posedge clock) begin
      typed_type t;
      if (!reset && req_bus.valid && req_bus.ready) begin
         t = typed_force_q.pop_front();
         if (t.known) force_expected_q.push_back(t.value);
         else force_expected_q.push_back(predict_force({req_bus.north_west_value,
            req_bus.north_value, req_bus.north_east_value, req_bus.east_value,
            req_bus.south_east_value, req_bus.south_value, req_bus.south_west_value,
            req_bus.west_value, req_bus.center_value}, strength_copy));
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      force_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (force_expected_q.size() == 0) begin
            $display("%0t: unexpected word fx=%0d fy=%0d", $time,
                     rsp_bus.force_x, rsp_bus.force_y);
            error_count++;
         end else begin
            want = force_expected_q.pop_front();
            if (rsp_bus.force_x !== want.fx) begin
               $display("%0t: force_x expected %0d actual %0d", $time, want.fx,
                        rsp_bus.force_x);
               error_count++;
            end
            if (rsp_bus.force_y !== want.fy) begin
               $display("%0t: force_y expected %0d actual %0d", $time, want.fy,
                        rsp_bus.force_y);
               error_count++;
            end
         end
      end
   end

   // result side back-pressure
   always @(posedge clock)
      rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 16);

   // watchdog on cycles with nothing accepted
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_hood(hood_type h, logic known, force_type value);
      typed_force_q.push_back({known, value});
      // one idle cycle now and then, about 19 in a hundred outside the calm phase
      if (!calm && $urandom_range(0, 99) < 19) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.north_west_value <= h.nw;
      req_bus.north_value      <= h.n;
      req_bus.north_east_value <= h.ne;
      req_bus.east_value       <= h.e;
      req_bus.south_east_value <= h.se;
      req_bus.south_value      <= h.s;
      req_bus.south_west_value <= h.sw;
      req_bus.west_value       <= h.w;
      req_bus.center_value     <= h.c;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (force_expected_q.size() != 0 || typed_force_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic hood_type random_hood();
      hood_type h;
      sample_type flat;
      h = hood_type'({$urandom, $urandom, $urandom});
      case ($urandom_range(0, 9))
         0: begin   // flat patch, zero gradient
            flat = sample_type'($urandom);
            h = {flat, flat, flat, flat, flat, flat, flat, flat, sample_type'($urandom)};
         end
         1: h.c = $urandom_range(0, 1) ? sample_type'(SMAX) : '0;
         2: begin   // left against right edge
            h.ne = '0; h.e = '0; h.se = '0;
            h.nw = sample_type'(SMAX); h.w = sample_type'(SMAX); h.sw = sample_type'(SMAX);
         end
         default: ;
      endcase
      return h;
   endfunction

   row_type directed[] = '{
      '{'{0, 0, 0, 0, 0, 0, 0, 0, 0},             1, '{0, 0}},
      '{'{255, 255, 255, 255, 255, 255, 255, 255, 255}, 1, '{0, 0}},
      '{'{255, 0, 0, 0, 0, 0, 255, 255, 255},     1, '{256, 0}},
      '{'{0, 0, 255, 255, 255, 0, 0, 0, 255},     1, '{-256, 0}},
      '{'{255, 255, 255, 0, 0, 0, 0, 0, 255},     1, '{0, 256}},
      '{'{0, 0, 0, 0, 255, 255, 255, 0, 255},     1, '{0, -256}},
      '{'{255, 0, 0, 0, 0, 0, 0, 0, 255},         1, '{181, 181}},
      '{'{255, 0, 0, 0, 0, 0, 255, 255, 0},       1, '{0, 0}},
      '{'{255, 0, 0, 0, 0, 0, 255, 255, 1},       0, '{0, 0}},
      '{'{170, 85, 60, 3, 250, 17, 99, 201, 128}, 0, '{0, 0}},
      '{'{0, 255, 0, 255, 0, 255, 0, 255, 255},   0, '{0, 0}},
      '{'{1, 2, 4, 8, 16, 32, 64, 128, 127},      0, '{0, 0}},
      '{'{254, 253, 251, 247, 239, 223, 191, 127, 200}, 0, '{0, 0}}
   };

   logic [STBITS-1:0] phase_strength[NUM_PHASES] = '{
      gfv_pkg::STRENGTH_RESET, 16'd0, 16'hFFFF, 16'd1, 16'h5A3C, 16'hA5C3, 16'd256, 16'd0
   };

   initial begin
      req_bus.valid            = 1'b0;
      req_bus.north_west_value = '0;
      req_bus.north_value      = '0;
      req_bus.north_east_value = '0;
      req_bus.east_value       = '0;
      req_bus.south_east_value = '0;
      req_bus.south_value      = '0;
      req_bus.south_west_value = '0;
      req_bus.west_value       = '0;
      req_bus.center_value     = '0;
      rsp_bus.ready            = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at the reset strength
      foreach (directed[i]) send_hood(directed[i].hood, directed[i].known, directed[i].value);

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p != 0) begin
            drain();
            if (p == NUM_PHASES - 1) phase_strength[p] = STBITS'($urandom);
            csr_write_enable <= 1'b1;
            csr_write_data   <= phase_strength[p];
            @(posedge clock);
            csr_write_enable <= 1'b0;
            strength_copy = phase_strength[p];
         end
         calm = (p == 3);
         for (int k = 0; k < RAND_PER_PHASE; k++) send_hood(random_hood(), 1'b0, '0);
      end
      calm = 1'b0;
      drain();

      if (error_count == 0 && force_expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
